// File: hw/rtl/mmx_pkg.sv
package mmx_pkg;

    localparam int VAL_W = 31;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic [7:0] CHAR_AMP    = 8'h26;
    localparam logic [7:0] CHAR_BAR    = 8'h7C;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Operator stack entry codes.
    typedef enum logic [1:0] {
        OP_OPEN = 2'd0,
        OP_MIN  = 2'd1,
        OP_MAX  = 2'd2
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the input beat
        logic acc_digit;  // fold a digit into the open number
        logic close_num;  // push the open number, if any
        logic read_top;   // fetch the entries under both stack tops
        logic pop_apply;  // pop the top operator and apply it
        logic push_op;    // push the operator of the held character
        logic load_out;   // capture the result and clear for the next expression
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_digit;
        logic is_minmax;
        logic is_lparen;
        logic is_rparen;
        logic last;
        logic op_empty;
        logic op_top_open;
    } dp_stat_t;

endpackage

// File: hw/rtl/mmx_if.sv
interface mmx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

interface mmx_out_if;
    logic                      valid;
    logic                      ready;
    logic [mmx_pkg::VAL_W-1:0] value;
    logic                      no_value;
    logic                      malformed;

    modport source (output valid, output value, output no_value, output malformed,
                    input ready);
    modport sink (input valid, input value, input no_value, input malformed,
                  output ready);
endinterface

// File: hw/rtl/mmx_datapath.sv
module mmx_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                character,
    input  logic                      last,
    input  mmx_pkg::dp_cmd_t          cmd,
    output mmx_pkg::dp_stat_t         stat,
    output logic [mmx_pkg::VAL_W-1:0] value,
    output logic                      no_value,
    output logic                      malformed
);
    import mmx_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    // The top entry of each stack lives in a register; the memories hold the rest.
    logic [VAL_W-1:0] vmem [STACK_DEPTH];
    op_t              omem [STACK_DEPTH];

    logic [7:0]       char_reg;
    logic             last_reg;
    logic [VAL_W-1:0] val_top_reg;
    op_t              op_top_reg;
    logic [VAL_W-1:0] vrd_reg;
    op_t              ord_reg;
    logic [VAL_W-1:0] value_reg;
    logic             no_value_reg;
    logic             malformed_reg;

    logic [CW-1:0]    vcnt_reg, vcnt_next;
    logic [CW-1:0]    ocnt_reg, ocnt_next;
    logic [VAL_W-1:0] pending_reg, pending_next;
    logic             num_open_reg, num_open_next;
    logic             err_reg, err_next;

    logic [VAL_W+3:0] acc_sum;
    logic [VAL_W-1:0] acc_sat;
    logic [CW-1:0]    vcnt_m1, vcnt_m2, ocnt_m1, ocnt_m2;
    logic [AW-1:0]    vaddr_wr, vaddr_rd, oaddr_wr, oaddr_rd;
    logic             v_room, o_room, v_pair;
    logic             do_vpush, do_opush, do_combine;
    logic [VAL_W-1:0] combined;
    op_t              new_op;

    assign vcnt_m1  = vcnt_reg - ONE_C;
    assign vcnt_m2  = vcnt_reg - TWO_C;
    assign ocnt_m1  = ocnt_reg - ONE_C;
    assign ocnt_m2  = ocnt_reg - TWO_C;
    assign vaddr_wr = vcnt_m1[AW-1:0];
    assign oaddr_wr = ocnt_m1[AW-1:0];
    assign vaddr_rd = (vcnt_reg >= TWO_C) ? vcnt_m2[AW-1:0] : '0;
    assign oaddr_rd = (ocnt_reg >= TWO_C) ? ocnt_m2[AW-1:0] : '0;

    assign v_room = (vcnt_reg < DEPTH_C);
    assign o_room = (ocnt_reg < DEPTH_C);
    assign v_pair = (vcnt_reg >= TWO_C);

    assign do_vpush   = cmd.close_num && num_open_reg && v_room;
    assign do_opush   = cmd.push_op && o_room;
    assign do_combine = cmd.pop_apply && (op_top_reg != OP_OPEN) && v_pair;

    // Decimal accumulate: pending * 10 + digit, saturating.
    assign acc_sum = ({4'b0, pending_reg} << 3) + ({4'b0, pending_reg} << 1)
                   + {{VAL_W{1'b0}}, char_reg[3:0]};
    assign acc_sat = (acc_sum > {4'b0, VAL_MAX}) ? VAL_MAX : acc_sum[VAL_W-1:0];

    always_comb
    begin
        if (op_top_reg == OP_MIN)
        begin
            combined = (vrd_reg < val_top_reg) ? vrd_reg : val_top_reg;
        end
        else
        begin
            combined = (vrd_reg > val_top_reg) ? vrd_reg : val_top_reg;
        end
    end

    always_comb
    begin
        if (char_reg == CHAR_AMP)
        begin
            new_op = OP_MIN;
        end
        else if (char_reg == CHAR_BAR)
        begin
            new_op = OP_MAX;
        end
        else
        begin
            new_op = OP_OPEN;
        end
    end

    always_comb
    begin
        vcnt_next     = vcnt_reg;
        ocnt_next     = ocnt_reg;
        pending_next  = pending_reg;
        num_open_next = num_open_reg;
        err_next      = err_reg;
        if (cmd.load_out)
        begin
            vcnt_next     = '0;
            ocnt_next     = '0;
            pending_next  = '0;
            num_open_next = 1'b0;
            err_next      = 1'b0;
        end
        if (cmd.acc_digit)
        begin
            pending_next  = acc_sat;
            num_open_next = 1'b1;
        end
        if (cmd.close_num && num_open_reg)
        begin
            if (v_room)
            begin
                vcnt_next = vcnt_reg + ONE_C;
            end
            else
            begin
                err_next = 1'b1;
            end
            pending_next  = '0;
            num_open_next = 1'b0;
        end
        if (cmd.push_op)
        begin
            if (o_room)
            begin
                ocnt_next = ocnt_reg + ONE_C;
            end
            else
            begin
                err_next = 1'b1;
            end
        end
        if (cmd.pop_apply)
        begin
            ocnt_next = ocnt_m1;
            if (op_top_reg != OP_OPEN)
            begin
                if (v_pair)
                begin
                    vcnt_next = vcnt_m1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg     <= '0;
            ocnt_reg     <= '0;
            pending_reg  <= '0;
            num_open_reg <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            vcnt_reg     <= vcnt_next;
            ocnt_reg     <= ocnt_next;
            pending_reg  <= pending_next;
            num_open_reg <= num_open_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            char_reg <= character;
            last_reg <= last;
        end
        if (do_vpush)
        begin
            val_top_reg <= pending_reg;
        end
        else if (do_combine)
        begin
            val_top_reg <= combined;
        end
        if (do_opush)
        begin
            op_top_reg <= new_op;
        end
        else if (cmd.pop_apply)
        begin
            op_top_reg <= ord_reg;
        end
        if (cmd.load_out)
        begin
            value_reg     <= (vcnt_reg != '0) ? val_top_reg : '0;
            no_value_reg  <= (vcnt_reg == '0);
            malformed_reg <= err_reg;
        end
    end

    // Stack memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (do_vpush && (vcnt_reg != '0))
        begin
            vmem[vaddr_wr] <= val_top_reg;
        end
        if (cmd.read_top)
        begin
            vrd_reg <= vmem[vaddr_rd];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_opush && (ocnt_reg != '0))
        begin
            omem[oaddr_wr] <= op_top_reg;
        end
        if (cmd.read_top)
        begin
            ord_reg <= omem[oaddr_rd];
        end
    end

    assign stat.is_digit    = (char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE);
    assign stat.is_minmax   = (char_reg == CHAR_AMP) || (char_reg == CHAR_BAR);
    assign stat.is_lparen   = (char_reg == CHAR_LPAREN);
    assign stat.is_rparen   = (char_reg == CHAR_RPAREN);
    assign stat.last        = last_reg;
    assign stat.op_empty    = (ocnt_reg == '0);
    assign stat.op_top_open = (op_top_reg == OP_OPEN);

    assign value     = value_reg;
    assign no_value  = no_value_reg;
    assign malformed = malformed_reg;

endmodule

// File: hw/rtl/mmx_ctrl.sv
module mmx_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mmx_pkg::dp_stat_t stat,
    output mmx_pkg::dp_cmd_t  cmd
);
    import mmx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REDUCE,
        S_APPLY_R,
        S_APPLY_P,
        S_PUSHOP,
        S_FIN_CLOSE,
        S_FLUSH,
        S_APPLY_F,
        S_OUT
    } state_t;

    state_t state_reg, state_next, done_state;
    logic   out_valid_reg, out_valid_next;

    // Where a character's work ends: back to idle, or on to the final flush.
    assign done_state = stat.last ? S_FIN_CLOSE : S_IDLE;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_digit)
                begin
                    cmd.acc_digit = 1'b1;
                    state_next    = done_state;
                end
                else
                begin
                    cmd.close_num = 1'b1;
                    if (stat.is_minmax || stat.is_rparen)
                    begin
                        state_next = S_REDUCE;
                    end
                    else if (stat.is_lparen)
                    begin
                        state_next = S_PUSHOP;
                    end
                    else
                    begin
                        state_next = done_state;
                    end
                end
            end
            S_REDUCE:
            begin
                if (!stat.op_empty && !stat.op_top_open)
                begin
                    cmd.read_top = 1'b1;
                    state_next   = S_APPLY_R;
                end
                else if (stat.is_rparen)
                begin
                    if (!stat.op_empty)
                    begin
                        cmd.read_top = 1'b1;
                        state_next   = S_APPLY_P;
                    end
                    else
                    begin
                        state_next = done_state;
                    end
                end
                else
                begin
                    state_next = S_PUSHOP;
                end
            end
            S_APPLY_R:
            begin
                cmd.pop_apply = 1'b1;
                state_next    = S_REDUCE;
            end
            S_APPLY_P:
            begin
                cmd.pop_apply = 1'b1;
                state_next    = done_state;
            end
            S_PUSHOP:
            begin
                cmd.push_op = 1'b1;
                state_next  = done_state;
            end
            S_FIN_CLOSE:
            begin
                cmd.close_num = 1'b1;
                state_next    = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (stat.op_empty)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.read_top = 1'b1;
                    state_next   = S_APPLY_F;
                end
            end
            S_APPLY_F:
            begin
                cmd.pop_apply = 1'b1;
                state_next    = S_FLUSH;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/minmax_expression_evaluator_unit.sv
// Channel  Modport  Beat payload                      Meaning
// -------  -------  --------------------------------  ---------------------------------
// expr     sink     character[7:0], last              one byte of expression text
// result   source   value[30:0], no_value, malformed  one result per expression
//
// A digit or a skipped byte ends in decode; '(' adds an operator push. '&' and '|' apply
// each operator above the last '(' (equal precedence bounds that to one), then push; ')'
// applies the same way, then pops its '(' if any. Each apply is a registered stack read
// and then the pop. A beat marked last closes the open number and flushes the stack.
// Reset clears counts, flags and the open number; entries read above the counts go unused.
// Only a result that finds the previous one still waiting in the output register stalls.
module minmax_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 64
) (
    input logic      clk,
    input logic      rst_n,
    mmx_in_if.sink   expr,
    mmx_out_if.source result
);
    import mmx_pkg::*;

    // Commands and status between the sequencer and the stack datapath.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller walks one byte at a time through decode, reduce and
    // push steps, and runs the final flush loop when the last beat arrives.
    mmx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (expr.valid),
        .in_ready  (expr.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds both stacks, their counts, the number being built,
    // the error flag and the output register.
    mmx_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .character (expr.character),
        .last      (expr.last),
        .cmd       (cmd),
        .stat      (stat),
        .value     (result.value),
        .no_value  (result.no_value),
        .malformed (result.malformed)
    );

endmodule

// File: bench/minmax_expression_evaluator_unit_test.sv
`timescale 1ns / 100ps

module minmax_expression_evaluator_unit_test;

    import mmx_pkg::*;

    // The block under test keeps its default stack depth; the predictor must agree.
    localparam int DEPTH = 64;

    // A cycle with no beat on either channel counts toward the watchdog. The longest
    // legal quiet stretch is the deliberate receiver hold-off.
    localparam int STALL_LIMIT = 4000;

    // After the last result, a full flush of a deep operator stack plus a receiver
    // stall fits well inside this window; any stray result in it is a failure.
    localparam int DRAIN_CYCLES = 200;

    localparam int TOTAL_ITEMS = 1500;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             no_value;
        logic             malformed;
    } expr_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mmx_in_if expr_bus ();
    mmx_out_if result_bus ();

    minmax_expression_evaluator_unit #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .expr(expr_bus),
        .result(result_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the evaluator state. It is updated when a beat is offered, which
    // keeps the order of expressions since the sender only offers one beat at a time.
    logic [VAL_W-1:0] val_stk [DEPTH];
    int               val_cnt;
    op_t              opr_stk [DEPTH];
    int               opr_cnt;
    logic [VAL_W-1:0] run_value;
    bit               run_open;
    bit               flag_malformed;

    // Results the evaluator owes us, oldest first.
    expr_result_t awaited_results[$];

    int  mismatch_count = 0;
    int  sent_beats = 0;
    bit  sender_fast = 1'b0;
    bit  receiver_fast = 1'b0;
    int  hold_request = 0;

    function automatic void eval_clear();
        val_cnt = 0;
        opr_cnt = 0;
        run_value = '0;
        run_open = 1'b0;
        flag_malformed = 1'b0;
    endfunction

    function automatic void eval_push_value(logic [VAL_W-1:0] v);
        if (val_cnt < DEPTH)
        begin
            val_stk[val_cnt] = v;
            val_cnt++;
        end
        else
            flag_malformed = 1'b1;
    endfunction

    function automatic void eval_push_op(op_t op);
        if (opr_cnt < DEPTH)
        begin
            opr_stk[opr_cnt] = op;
            opr_cnt++;
        end
        else
            flag_malformed = 1'b1;
    endfunction

    // Pop the top operator and fold the two top values if it is a min or a max.
    function automatic void eval_apply_op();
        op_t              top;
        logic [VAL_W-1:0] lhs;
        logic [VAL_W-1:0] rhs;
        if (opr_cnt == 0)
            return;
        opr_cnt--;
        top = opr_stk[opr_cnt];
        if (top == OP_OPEN)
            return;
        if (val_cnt < 2)
        begin
            flag_malformed = 1'b1;
            return;
        end
        val_cnt--;
        rhs = val_stk[val_cnt];
        lhs = val_stk[val_cnt - 1];
        if (top == OP_MIN)
            val_stk[val_cnt - 1] = (lhs < rhs) ? lhs : rhs;
        else
            val_stk[val_cnt - 1] = (lhs > rhs) ? lhs : rhs;
    endfunction

    function automatic void eval_reduce();
        while (opr_cnt > 0 && opr_stk[opr_cnt - 1] != OP_OPEN)
            eval_apply_op();
    endfunction

    function automatic void eval_close_run();
        if (run_open)
        begin
            eval_push_value(run_value);
            run_open = 1'b0;
            run_value = '0;
        end
    endfunction

    // Advance the shadow evaluator by one byte and queue a result on the final one.
    function automatic void eval_char(logic [7:0] ch, logic lst);
        longint       grown;
        expr_result_t r;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            grown = longint'(run_value) * 10 + longint'(ch - CHAR_ZERO);
            run_value = (grown > longint'(VAL_MAX)) ? VAL_MAX : grown[VAL_W-1:0];
            run_open = 1'b1;
        end
        else
        begin
            eval_close_run();
            if (ch == CHAR_AMP || ch == CHAR_BAR)
            begin
                eval_reduce();
                eval_push_op((ch == CHAR_AMP) ? OP_MIN : OP_MAX);
            end
            else if (ch == CHAR_LPAREN)
                eval_push_op(OP_OPEN);
            else if (ch == CHAR_RPAREN)
            begin
                eval_reduce();
                if (opr_cnt > 0)
                    opr_cnt--;
            end
        end
        if (lst)
        begin
            eval_close_run();
            while (opr_cnt > 0)
                eval_apply_op();
            r.value = (val_cnt > 0) ? val_stk[val_cnt - 1] : '0;
            r.no_value = (val_cnt == 0);
            r.malformed = flag_malformed;
            awaited_results.push_back(r);
            eval_clear();
        end
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic bit is_token(logic [7:0] b);
        return (b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_AMP || b == CHAR_BAR ||
               b == CHAR_LPAREN || b == CHAR_RPAREN;
    endfunction

    // Offer one beat. The sender first idles for a drawn number of cycles, then holds
    // valid until the beat is taken. Valid is left high afterwards so that a back-to-back
    // beat never sees valid dropped and raised within one time step; the next call either
    // replaces the payload at once or lowers valid for its own gap.
    task automatic send_beat(input logic [7:0] ch, input logic lst);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            expr_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expr_bus.valid <= 1'b1;
        expr_bus.character <= ch;
        expr_bus.last <= lst;
        eval_char(ch, lst);
        sent_beats++;
        @(posedge clk);
        while (!expr_bus.ready)
            @(posedge clk);
    endtask

    task automatic send_text(input byte_q_t txt);
        foreach (txt[i])
            send_beat(txt[i], i == txt.size() - 1);
    endtask

    task automatic send_string(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        send_text(q);
    endtask

    // Numbers are mostly short; about one in ten runs to nine to thirteen digits, with a
    // bias toward nines so that the limit is crossed often.
    function automatic void add_number(ref byte_q_t q);
        int len;
        bit heavy;
        heavy = ($urandom_range(0, 9) == 0);
        len = heavy ? $urandom_range(9, 13) : $urandom_range(1, 4);
        repeat (len)
        begin
            if (heavy && $urandom_range(0, 1))
                q.push_back(CHAR_NINE);
            else
                q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void add_separator(ref byte_q_t q);
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0: q.push_back(CHAR_SPACE);
            1: q.push_back(CHAR_TAB);
            default:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (is_token(b));
                q.push_back(b);
            end
        endcase
    endfunction

    // Most expressions are well formed with random numbers, operators, nesting and
    // spacing, a tenth of those with one byte dropped or injected. The rest is a soup
    // of random tokens or plain random bytes.
    function automatic byte_q_t make_expression();
        byte_q_t q;
        int      kind;
        int      depth;
        int      terms;
        int      pos;
        int      n;
        kind = $urandom_range(0, 99);
        if (kind < 78)
        begin
            depth = 0;
            terms = $urandom_range(1, 6);
            for (int t = 0; t < terms; t++)
            begin
                while (depth < 5 && $urandom_range(0, 3) == 0)
                begin
                    q.push_back(CHAR_LPAREN);
                    depth++;
                end
                add_number(q);
                if ($urandom_range(0, 3) == 0)
                    add_separator(q);
                while (depth > 0 && $urandom_range(0, 2) == 0)
                begin
                    q.push_back(CHAR_RPAREN);
                    depth--;
                end
                if (t < terms - 1)
                begin
                    if ($urandom_range(0, 3) == 0)
                        add_separator(q);
                    q.push_back($urandom_range(0, 1) ? CHAR_AMP : CHAR_BAR);
                    if ($urandom_range(0, 3) == 0)
                        add_separator(q);
                end
            end
            while (depth > 0)
            begin
                q.push_back(CHAR_RPAREN);
                depth--;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                pos = $urandom_range(0, q.size() - 1);
                if ($urandom_range(0, 1))
                    q.delete(pos);
                else
                    q.insert(pos, 8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 90)
        begin
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0: add_number(q);
                    1: q.push_back(CHAR_AMP);
                    2: q.push_back(CHAR_BAR);
                    3: q.push_back(CHAR_LPAREN);
                    4: q.push_back(CHAR_RPAREN);
                    default: add_separator(q);
                endcase
            end
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                q.push_back(8'($urandom_range(0, 255)));
        end
        if (q.size() == 0 || $urandom_range(0, 4) == 0)
            add_separator(q);
        return q;
    endfunction

    // Every operator, grouping, an unmatched close and open, a missing operand, runs
    // ended by a space, and final bytes that carry no number at all (all-ones and zero).
    task automatic test_operators();
        send_string("7&3");
        send_string("(2|8)&5");
        send_string(")4");
        send_string("&6");
        send_string("(9");
        send_string("1 2");
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b1);
    endtask

    // Values at, just under and above the top of the range, and leading zeros.
    task automatic test_saturation();
        send_string("2147483646");
        send_string("2147483647");
        send_string("2147483648");
        send_string("99999999999999");
        send_string("0000");
    endtask

    // Both stacks filled exactly; the value stack pushed one entry past full, the operator stack six.
    task automatic test_stack_limits();
        string s;
        s = "";
        for (int k = 1; k <= DEPTH; k++)
            s = {s, $sformatf("%0d ", k)};
        send_string(s);
        send_string({s, "77"});
        s = "";
        repeat (DEPTH + 6)
            s = {s, "("};
        send_string({s, "3"});
        // Two operator entries per level: this fills the operator stack to the brim and
        // leaves a long chain of applies for the final flush.
        s = "";
        repeat (DEPTH / 2)
            s = {s, "1|("};
        send_string({s, "2"});
    endtask

    // The receiver stops taking results for a long stretch while the sender offers
    // beats back to back; one result waits in the output register, the next one backs
    // up inside the block and the input channel has to stall.
    task automatic test_backpressure();
        hold_request = 400;
        sender_fast = 1'b1;
        repeat (10)
            send_string("8|3&5");
        sender_fast = 1'b0;
    endtask

    // Random expressions until the whole run has sent enough beats. Each expression
    // also draws whether either side runs without idling, giving unbroken stretches.
    task automatic test_random();
        byte_q_t txt;
        while (sent_beats < TOTAL_ITEMS)
        begin
            txt = make_expression();
            sender_fast = ($urandom_range(0, 7) == 0);
            receiver_fast = ($urandom_range(0, 7) == 0);
            send_text(txt);
        end
        sender_fast = 1'b0;
        receiver_fast = 1'b0;
    endtask

    // Result side: take each beat, compare it with the oldest expectation, then draw
    // how long to wait before the next one. A hold-off request overrides the draw.
    initial
    begin
        expr_result_t want;
        int           wait_left;
        int           hold_left;
        wait_left = 0;
        hold_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (awaited_results.size() == 0)
                    note_mismatch($sformatf(
                        "result with nothing expected: value=%0d no_value=%0b malformed=%0b",
                        result_bus.value, result_bus.no_value, result_bus.malformed));
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_bus.value !== want.value ||
                        result_bus.no_value !== want.no_value ||
                        result_bus.malformed !== want.malformed)
                        note_mismatch($sformatf(
                            {"result mismatch: expected value=%0d no_value=%0b ",
                             "malformed=%0b, got value=%0d no_value=%0b malformed=%0b"},
                            want.value, want.no_value, want.malformed,
                            result_bus.value, result_bus.no_value,
                            result_bus.malformed));
                end
                wait_left = receiver_fast ? 0 : $urandom_range(0, 12);
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((expr_bus.valid && expr_bus.ready) || (result_bus.valid && result_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence: reset once, run each test in turn, then wait for every owed result
    // and watch a quiet window for anything extra before the verdict.
    initial
    begin
        rst_n <= 1'b0;
        expr_bus.valid <= 1'b0;
        expr_bus.character <= '0;
        expr_bus.last <= 1'b0;
        eval_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operators();
        test_saturation();
        test_stack_limits();
        test_backpressure();
        test_random();

        expr_bus.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: minmax_expression_evaluator_unit.f
hw/rtl/mmx_pkg.sv
hw/rtl/mmx_if.sv
hw/rtl/mmx_datapath.sv
hw/rtl/mmx_ctrl.sv
hw/rtl/minmax_expression_evaluator_unit.sv
bench/minmax_expression_evaluator_unit_test.sv
